@@ rtl/lnr_pkg.sv @@
package lnr_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int STEP_BITS  = COORD_BITS + 3;
    localparam int DEC_BITS   = COORD_BITS + 4;

    localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef enum logic [3:0] {
        OCT_SHALLOW_RISE = 4'b0001,
        OCT_SHALLOW_FALL = 4'b0010,
        OCT_STEEP_RISE   = 4'b0100,
        OCT_STEEP_FALL   = 4'b1000
    } octant_t;

    typedef struct packed {
        logic                         last;
        logic [COLOR_BITS-1:0]        color;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } pixel_t;

endpackage

@@ rtl/lnr_skid.sv @@
module lnr_skid
    import lnr_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    input  pixel_t in_pix,
    output logic   in_ready,
    output logic   out_valid,
    output pixel_t out_pix,
    input  logic   out_ready
);

    logic   out_valid_reg;
    pixel_t out_pix_reg;
    logic   skid_valid_reg;
    pixel_t skid_pix_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !out_ready) begin
            if (in_valid && !skid_valid_reg) begin
                skid_valid_reg <= 1'b1;
                skid_pix_reg   <= in_pix;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            out_pix_reg    <= skid_pix_reg;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= in_valid;
            out_pix_reg   <= in_pix;
        end
    end

endmodule

@@ rtl/line_rasterizer.sv @@
// Line rasterizer for all octants, midpoint (Bresenham) stepping.
// The slave channel takes one transfer per command. s_tuser low loads a new
// line from s_tdata: both endpoints and a color. A load gives no pixel and
// replaces any line in progress. s_tuser high advances the active line by
// one pixel; with no line active the transfer is taken and gives nothing.
// Each advance gives one master transfer with the pixel position and color,
// and m_tlast marks the final pixel. The endpoint with the greater x (the
// end point if both x match) is not plotted; equal endpoints give no pixels.
// Throughput is one command per cycle while s_tready is high. A pixel
// reaches the master side from the output register after its advance transfer.
// A skid register behind the output register holds one more pixel while the
// receiver stalls; commands keep being taken until it fills, and s_tready
// drops only while the skid register is full.
// After reset (aresetn low at a clock edge) no line is active and the
// master channel is empty.
module line_rasterizer
    import lnr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // start_x, start_y, end_x, end_y, line_color
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    // mode
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    output logic                      m_tlast
);

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] stop_x_reg, stop_y_reg;
    logic signed [DEC_BITS-1:0]   dec_reg, dec_next;
    logic signed [STEP_BITS-1:0]  step_a_reg, step_b_reg;
    octant_t                      oct_reg;
    logic                         active_reg;
    logic [COLOR_BITS-1:0]        color_reg;

    logic signed [COORD_BITS-1:0] in_x0, in_y0, in_x1, in_y1;
    logic [COLOR_BITS-1:0]        in_color;
    logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
    logic signed [DIFF_BITS-1:0]  diff_a, diff_b, diff_dx, diff_ady;
    logic signed [DEC_BITS-1:0]   dec_a, dec_b, load_dec;
    octant_t                      load_oct;
    logic                         last;

    logic   in_fire, pix_valid, skid_ready;
    pixel_t pix, out_pix;

    assign in_x0    = s_tdata[COORD_BITS-1:0];
    assign in_y0    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_x1    = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign in_y1    = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
    assign in_color = s_tdata[IN_FIELD_BITS-1:4*COORD_BITS];

    always_comb begin
        if (in_x1 < in_x0) begin
            x0 = in_x1;
            y0 = in_y1;
            x1 = in_x0;
            y1 = in_y0;
        end else begin
            x0 = in_x0;
            y0 = in_y0;
            x1 = in_x1;
            y1 = in_y1;
        end
        diff_a   = DIFF_BITS'(y1) - DIFF_BITS'(y0);
        diff_b   = DIFF_BITS'(x0) - DIFF_BITS'(x1);
        diff_dx  = DIFF_BITS'(x1) - DIFF_BITS'(x0);
        diff_ady = (diff_a < 0) ? -diff_a : diff_a;
        dec_a    = DEC_BITS'(diff_a);
        dec_b    = DEC_BITS'(diff_b);
        if (diff_dx >= diff_ady) begin
            if (y1 > y0) begin
                load_oct = OCT_SHALLOW_RISE;
                load_dec = dec_a + dec_a + dec_b;
            end else begin
                load_oct = OCT_SHALLOW_FALL;
                load_dec = dec_a + dec_a - dec_b;
            end
        end else begin
            if (y1 > y0) begin
                load_oct = OCT_STEEP_RISE;
                load_dec = dec_a + dec_b + dec_b;
            end else begin
                load_oct = OCT_STEEP_FALL;
                load_dec = dec_a - dec_b - dec_b;
            end
        end
    end

    always_comb begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        dec_next   = dec_reg;
        unique case (oct_reg)
            OCT_SHALLOW_RISE: begin
                if (dec_reg > 0) begin
                    cur_y_next = cur_y_reg + COORD_BITS'(1);
                    dec_next   = dec_next + DEC_BITS'(step_b_reg);
                end
                cur_x_next = cur_x_reg + COORD_BITS'(1);
                dec_next   = dec_next + DEC_BITS'(step_a_reg);
                last       = (cur_x_next >= stop_x_reg);
            end
            OCT_SHALLOW_FALL: begin
                if (dec_reg < 0) begin
                    cur_y_next = cur_y_reg - COORD_BITS'(1);
                    dec_next   = dec_next - DEC_BITS'(step_b_reg);
                end
                cur_x_next = cur_x_reg + COORD_BITS'(1);
                dec_next   = dec_next + DEC_BITS'(step_a_reg);
                last       = (cur_x_next >= stop_x_reg);
            end
            OCT_STEEP_RISE: begin
                if (dec_reg < 0) begin
                    cur_x_next = cur_x_reg + COORD_BITS'(1);
                    dec_next   = dec_next + DEC_BITS'(step_a_reg);
                end
                cur_y_next = cur_y_reg + COORD_BITS'(1);
                dec_next   = dec_next + DEC_BITS'(step_b_reg);
                last       = (cur_y_next >= stop_y_reg);
            end
            OCT_STEEP_FALL: begin
                if (dec_reg > 0) begin
                    cur_x_next = cur_x_reg + COORD_BITS'(1);
                    dec_next   = dec_next + DEC_BITS'(step_a_reg);
                end
                cur_y_next = cur_y_reg - COORD_BITS'(1);
                dec_next   = dec_next - DEC_BITS'(step_b_reg);
                last       = (cur_y_next <= stop_y_reg);
            end
            default: begin
                last = 1'b1;
            end
        endcase
    end

    assign in_fire   = s_tvalid && s_tready;
    assign pix_valid = in_fire && (s_tuser == MODE_ADVANCE) && active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            oct_reg    <= OCT_SHALLOW_RISE;
        end else if (in_fire && (s_tuser == MODE_LOAD)) begin
            cur_x_reg  <= x0;
            cur_y_reg  <= y0;
            stop_x_reg <= x1;
            stop_y_reg <= y1;
            dec_reg    <= load_dec;
            step_a_reg <= STEP_BITS'(diff_a) + STEP_BITS'(diff_a);
            step_b_reg <= STEP_BITS'(diff_b) + STEP_BITS'(diff_b);
            oct_reg    <= load_oct;
            color_reg  <= in_color;
            active_reg <= !((diff_dx == 0) && (diff_a == 0));
        end else if (pix_valid) begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            dec_reg   <= dec_next;
            if (last) begin
                active_reg <= 1'b0;
            end
        end
    end

    assign pix.x     = cur_x_reg;
    assign pix.y     = cur_y_reg;
    assign pix.color = color_reg;
    assign pix.last  = last;

    lnr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pix_valid),
        .in_pix    (pix),
        .in_ready  (skid_ready),
        .out_valid (m_tvalid),
        .out_pix   (out_pix),
        .out_ready (m_tready)
    );

    assign s_tready = skid_ready;
    assign m_tlast  = out_pix.last;

    always_comb begin
        m_tdata = '0;
        m_tdata[COORD_BITS-1:0]                = out_pix.x;
        m_tdata[2*COORD_BITS-1:COORD_BITS]     = out_pix.y;
        m_tdata[OUT_FIELD_BITS-1:2*COORD_BITS] = out_pix.color;
    end

endmodule
